[hw/rtl/radar_target_list_deframer_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the target list deframer
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef RADAR_TARGET_LIST_DEFRAMER_DEFINES_SVH
`define RADAR_TARGET_LIST_DEFRAMER_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define RTLD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check a condition in the cycle after its trigger
`define RTLD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rtld_pkg.sv]
// ---------------------------------------------------------------------------
// rtld_pkg
// Types and constants shared by the target list deframer modules.
// ---------------------------------------------------------------------------
package rtld_pkg;

  localparam int FRAME_BYTES  = 24;
  localparam int HEADER_BYTES = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] LIMIT_RESET = 8'd35;
  localparam logic [7:0] COUNT_CLIP  = 8'hFF;

  localparam logic [7:0] HEAD_SIG [4] = '{8'hFE, 8'hED, 8'h50, 8'h10};
  localparam logic [7:0] END_SIG  [4] = '{8'hFE, 8'hED, 8'h00, 8'h00};

  typedef enum logic [1:0] {
    KIND_TARGET   = 2'd0,
    KIND_LIST_END = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_CLIPPED   = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_BAD_HDR   = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_FRAMES  = 4'b0010,
    PH_ENDSKIP = 4'b0100,
    PH_DISCARD = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       msg_last;
  } item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  target_index;
    logic [31:0] signal_word;
    logic [31:0] range_word;
    logic [31:0] velocity_word;
    logic [31:0] angle_word;
    logic [31:0] spare_word_a;
    logic [31:0] spare_word_b;
    logic [7:0]  list_count;
    logic [2:0]  status;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic             has_target;
    logic [7:0]       target_index;
    logic [5:0][31:0] words;
    logic             has_tail;
    kind_t            tail_kind;
    logic [7:0]       tail_count;
    status_t          tail_status;
  } cmd_t;

endpackage

[hw/rtl/rtld_front.sv]
// ---------------------------------------------------------------------------
// rtld_front
// Byte parser: tracks header, frames and end block, builds result commands.
// ---------------------------------------------------------------------------
module rtld_front import rtld_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  item_t      item,
  input  logic [7:0] target_limit,
  output cmd_t       cmd,
  output logic       cmd_push
);

  phase_t      phase, phase_next;
  logic [4:0]  pos, pos_next;
  logic [31:0] word, word_next;
  logic        match, match_next;
  logic [7:0]  hdr_count, hdr_count_next;
  logic [7:0]  next_idx, next_idx_next;
  logic [31:0] held [5];
  logic        held_we;
  logic        errored;
  logic [7:0]  b;

  assign b = item.data_byte;

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    word_next      = word;
    match_next     = match;
    hdr_count_next = hdr_count;
    next_idx_next  = next_idx;
    held_we        = 1'b0;
    errored        = 1'b0;
    cmd            = '0;
    cmd.tail_kind  = KIND_ERROR;
    cmd.tail_status = ST_OK;

    case (phase)
      PH_HEADER: begin
        if (pos < 5'd4 && b != HEAD_SIG[pos[1:0]]) begin
          cmd.has_tail    = 1'b1;
          cmd.tail_kind   = KIND_ERROR;
          cmd.tail_status = ST_BAD_HDR;
          phase_next      = PH_DISCARD;
          errored         = 1'b1;
        end else if (pos >= 5'(HEADER_BYTES - 1)) begin
          hdr_count_next = b;
          next_idx_next  = '0;
          pos_next       = '0;
          match_next     = 1'b0;
          if (b != COUNT_CLIP && b > target_limit) begin
            cmd.has_tail    = 1'b1;
            cmd.tail_kind   = KIND_ERROR;
            cmd.tail_count  = b;
            cmd.tail_status = ST_TOO_MANY;
            phase_next      = PH_DISCARD;
            errored         = 1'b1;
          end else begin
            phase_next = PH_FRAMES;
          end
        end else begin
          pos_next = pos + 5'd1;
        end
      end
      PH_FRAMES: begin
        word_next = {word[23:0], b};
        if (pos < 5'd4) begin
          match_next = (pos == 5'd0 || match) && b == END_SIG[pos[1:0]];
        end
        if (pos[1:0] == 2'd3 && pos[4:2] < 3'd5) begin
          held_we = 1'b1;
        end
        if (pos == 5'd3 && match_next) begin
          cmd.has_tail   = 1'b1;
          cmd.tail_kind  = KIND_LIST_END;
          cmd.tail_count = hdr_count;
          if (hdr_count == COUNT_CLIP) begin
            cmd.tail_status = ST_CLIPPED;
          end else if (hdr_count == target_limit) begin
            cmd.tail_status = ST_FULL;
          end else begin
            cmd.tail_status = ST_OK;
          end
          phase_next = PH_ENDSKIP;
          pos_next   = 5'd4;
        end else if (pos >= 5'(FRAME_BYTES - 1)) begin
          if (hdr_count != COUNT_CLIP && next_idx < hdr_count) begin
            cmd.has_target   = 1'b1;
            cmd.target_index = next_idx;
            cmd.words[0]     = held[0];
            cmd.words[1]     = held[1];
            cmd.words[2]     = held[2];
            cmd.words[3]     = held[3];
            cmd.words[4]     = held[4];
            cmd.words[5]     = word_next;
          end
          if (next_idx != 8'hFF) begin
            next_idx_next = next_idx + 8'd1;
          end
          pos_next = '0;
        end else begin
          pos_next = pos + 5'd1;
        end
      end
      PH_ENDSKIP: begin
        if (pos >= 5'(HEADER_BYTES - 1)) begin
          phase_next = PH_HEADER;
          pos_next   = '0;
        end else begin
          pos_next = pos + 5'd1;
        end
      end
      PH_DISCARD: begin
        phase_next = PH_DISCARD;
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase

    if (item.msg_last) begin
      if (!errored && phase_next != PH_DISCARD && phase_next != PH_ENDSKIP &&
          !(phase_next == PH_HEADER && pos_next == 5'd0)) begin
        cmd.has_tail    = 1'b1;
        cmd.tail_kind   = KIND_ERROR;
        cmd.tail_count  = (phase_next == PH_FRAMES) ? hdr_count_next : 8'd0;
        cmd.tail_status = ST_TRUNCATED;
      end
      phase_next = PH_HEADER;
      pos_next   = '0;
      word_next  = '0;
      match_next = 1'b0;
    end
  end

  assign cmd_push = accept && (cmd.has_target || cmd.has_tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      pos       <= '0;
      word      <= '0;
      match     <= 1'b0;
      hdr_count <= '0;
      next_idx  <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      pos       <= pos_next;
      word      <= word_next;
      match     <= match_next;
      hdr_count <= hdr_count_next;
      next_idx  <= next_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held[pos[4:2]] <= {word[23:0], b};
    end
  end

endmodule

[hw/rtl/rtld_queue.sv]
// ---------------------------------------------------------------------------
// rtld_queue
// Short command queue between the parser and the result stage.
// ---------------------------------------------------------------------------
module rtld_queue import rtld_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QUEUE_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QUEUE_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

[hw/rtl/rtld_back.sv]
// ---------------------------------------------------------------------------
// rtld_back
// Result stage: expands each command into one or two result words.
// ---------------------------------------------------------------------------
module rtld_back import rtld_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  cmd_t    q_data,
  output logic    q_pop,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  logic    out_valid, out_valid_next;
  logic    tail_pending, tail_pending_next;
  result_t out_q, out_next;
  logic    load;

  assign load = !out_valid || pop;

  always_comb begin
    q_pop             = 1'b0;
    out_valid_next    = out_valid && !pop;
    tail_pending_next = tail_pending;
    out_next          = '0;
    if (load && !q_empty) begin
      out_valid_next = 1'b1;
      if (q_data.has_target && !tail_pending) begin
        out_next.record_kind   = KIND_TARGET;
        out_next.target_index  = q_data.target_index;
        out_next.signal_word   = q_data.words[0];
        out_next.range_word    = q_data.words[1];
        out_next.velocity_word = q_data.words[2];
        out_next.angle_word    = q_data.words[3];
        out_next.spare_word_a  = q_data.words[4];
        out_next.spare_word_b  = q_data.words[5];
        out_next.last_of_run   = !q_data.has_tail;
        if (q_data.has_tail) begin
          tail_pending_next = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        out_next.record_kind = q_data.tail_kind;
        out_next.list_count  = q_data.tail_count;
        out_next.status      = q_data.tail_status;
        out_next.last_of_run = 1'b1;
        tail_pending_next    = 1'b0;
        q_pop                = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      tail_pending <= 1'b0;
    end else begin
      out_valid    <= out_valid_next;
      tail_pending <= tail_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_q <= out_next;
    end
  end

  assign result = out_q;
  assign empty  = !out_valid;

endmodule

[hw/rtl/radar_target_list_deframer.sv]
// ---------------------------------------------------------------------------
// radar_target_list_deframer
// Parses target lists from a sensor byte stream into target, list-end and
// error results.
// ---------------------------------------------------------------------------
// Input: a queue-style port; a byte word enters when push is high and full
// is low. msg_last marks the final byte of a message.
// Output: a queue-style port; the oldest result sits on result while empty
// is low and leaves when pop is high.
// limit_we/limit_data write target_limit; write only while idle.
// Path: the edge that takes a byte writes the command it causes into the command
// queue; the result register loads it from there once the register is empty or popped.
// Throughput: one byte per cycle while full is low. A byte that yields a target
// and an error gives two results; the four-entry command queue absorbs that.
// Receiver stall: the result register holds; the command queue fills and
// full rises, so bytes are held off without loss.
// Reset: parser returns to header search, queues empty, target_limit = 35.
// ---------------------------------------------------------------------------
module radar_target_list_deframer import rtld_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  item_t      item,
  output logic       empty,
  input  logic       pop,
  output result_t    result,
  input  logic       limit_we,
  input  logic [7:0] limit_data
);

  logic [7:0] target_limit;
  logic       accept;
  cmd_t       cmd;
  logic       cmd_push;
  cmd_t       q_data;
  logic       q_empty;
  logic       q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_limit <= LIMIT_RESET;
    end else if (limit_we) begin
      target_limit <= limit_data;
    end
  end

  assign accept = push && !full;

  rtld_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .target_limit (target_limit),
    .cmd          (cmd),
    .cmd_push     (cmd_push)
  );

  rtld_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  rtld_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

[hw/rtl/rtld_checker.sv]
// ---------------------------------------------------------------------------
// rtld_checker
// Port-level checks on the deframer result channel.
// ---------------------------------------------------------------------------
`include "radar_target_list_deframer_defines.svh"

module rtld_checker import rtld_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  `RTLD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "result dropped while stalled")

  `RTLD_ASSERT_NOW(a_kind, !empty, result.record_kind == KIND_TARGET || result.record_kind == KIND_LIST_END || result.record_kind == KIND_ERROR, "bad record kind")

  `RTLD_ASSERT_NOW(a_target, !empty && result.record_kind == KIND_TARGET, result.status == ST_OK && result.list_count == 8'd0, "target carries status")

  `RTLD_ASSERT_NOW(a_tail, !empty && result.record_kind != KIND_TARGET, result.target_index == 8'd0 && result.signal_word == 32'd0 && result.spare_word_b == 32'd0 && result.last_of_run, "tail result malformed")

endmodule

bind radar_target_list_deframer rtld_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
